FILE: rtl/polynomial_string_hash_top_assert.svh
// Assertion macros for the polynomial string hash block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef POLYNOMIAL_STRING_HASH_TOP_ASSERT_SVH
`define POLYNOMIAL_STRING_HASH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/phs_pkg.sv
// Shared types and constants for the polynomial string hash block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package phs_pkg;

  localparam int HASH_W = 64;
  localparam int HALF_W = HASH_W / 2;
  localparam int CHAR_W = 8;

  // Queue between front and back; depth must be a power of two.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Configuration address: registers are 64 bits wide, at 8-byte spacing.
  localparam int CFG_AW = 4;
  localparam logic REG_BASE    = 1'b0;
  localparam logic REG_MODULUS = 1'b1;

  localparam logic [HASH_W-1:0] BASE_RESET = 64'd31;
  localparam logic [HASH_W-1:0] MOD_RESET  = 64'd1;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } phs_item_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [HASH_W-1:0] divisor;
  } phs_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [HASH_W-1:0] rem;
  } phs_div_rsp_t;

  typedef struct packed {
    logic div_busy;
    logic res_pending;
  } phs_stat_t;

endpackage

FILE: rtl/phs_fifo.sv
// Front part: a short queue of incoming characters in front of the accumulator.
// Depends on phs_pkg.
`timescale 1ns / 1ps

module phs_fifo import phs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  phs_item_t push_item,
  output logic      can_push,
  input  logic      pop,
  output logic      head_valid,
  output phs_item_t head_item
);

  phs_item_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     cnt_r;
  logic             do_push;
  logic             do_pop;

  assign can_push   = (cnt_r != (QAW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && can_push;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/phs_div.sv
// Restoring remainder unit: one quotient bit per cycle over the 64-bit sum.
// Depends on phs_pkg.
`timescale 1ns / 1ps

module phs_div import phs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  phs_div_req_t req,
  output phs_div_rsp_t rsp
);

  localparam int DIV_STEPS = HASH_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_STEPS - 1);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [HASH_W-1:0] rem_r;
  logic [HASH_W-1:0] dvd_r;
  logic [HASH_W-1:0] dsr_r;
  logic [HASH_W:0]   trial;
  logic [HASH_W:0]   rem_step;

  // Shift the next dividend bit into the partial remainder and subtract
  // the divisor where it fits.
  always_comb begin
    trial = {rem_r, dvd_r[HASH_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_step = trial - {1'b0, dsr_r};
    end else begin
      rem_step = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_step[HASH_W-1:0];
        dvd_r <= {dvd_r[HASH_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: rtl/phs_acc.sv
// Back part: multiplies and accumulates characters, reduces the sum at the end
// of a string when the modulus is non-zero and holds the result word. Depends on phs_pkg and phs_div.
`timescale 1ns / 1ps

module phs_acc import phs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [HASH_W-1:0] base,
  input  logic [HASH_W-1:0] modulus,
  input  logic              q_valid,
  input  phs_item_t         q_item,
  output logic              q_pop,
  output phs_stat_t         stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [HASH_W-1:0] out_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_DIV,
    S_OUT
  } state_t;

  state_t              state_r;
  logic [HASH_W-1:0]   sum_r;
  logic [HASH_W-1:0]   power_r;
  logic [HASH_W-1:0]   prod_r;
  logic [HASH_W-1:0]   p0_r;
  logic [HALF_W-1:0]   p1_r;
  logic [HALF_W-1:0]   p2_r;
  logic                last_r;
  logic [HASH_W-1:0]   res_r;
  logic                out_valid_r;
  logic [HASH_W-1:0]   out_data_r;

  logic [HASH_W+CHAR_W-1:0] cp_full;
  logic [HASH_W-1:0]        corr;
  logic [HASH_W-1:0]        prod;
  logic [HASH_W-1:0]        p0;
  logic [HASH_W-1:0]        p1_full;
  logic [HASH_W-1:0]        p2_full;
  logic [HASH_W-1:0]        sum_new;
  logic [HASH_W-1:0]        power_new;
  logic                     mod_zero;
  logic                     out_free;
  logic                     out_load;
  phs_div_req_t             div_req;
  phs_div_rsp_t             div_rsp;

  // Character times power: unsigned 64x8 product, then a correction of
  // power shifted by eight for a negative character.
  always_comb begin
    cp_full = power_r * q_item.char_code;
    corr    = q_item.char_code[CHAR_W-1] ?
              {power_r[HASH_W-CHAR_W-1:0], {CHAR_W{1'b0}}} : '0;
    prod    = cp_full[HASH_W-1:0] - corr;
    p0      = power_r[HALF_W-1:0] * base[HALF_W-1:0];
    p1_full = power_r[HALF_W-1:0] * base[HASH_W-1:HALF_W];
    p2_full = power_r[HASH_W-1:HALF_W] * base[HALF_W-1:0];
  end

  // Low 64 bits of power times base from the registered partial products.
  assign sum_new   = sum_r + prod_r;
  assign power_new = p0_r + {p1_r + p2_r, {HALF_W{1'b0}}};
  assign mod_zero  = (modulus == '0);
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == S_OUT) && out_free;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    div_req.start    = (state_r == S_ADD) && last_r && !mod_zero;
    div_req.dividend = sum_new;
    div_req.divisor  = modulus;
  end

  phs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      power_r     <= HASH_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            prod_r  <= prod;
            p0_r    <= p0;
            p1_r    <= p1_full[HALF_W-1:0];
            p2_r    <= p2_full[HALF_W-1:0];
            last_r  <= q_item.last_char;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (last_r) begin
            sum_r   <= '0;
            power_r <= HASH_W'(1);
            res_r   <= sum_new;
            state_r <= mod_zero ? S_OUT : S_DIV;
          end else begin
            sum_r   <= sum_new;
            power_r <= power_new;
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_r   <= div_rsp.rem;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.div_busy    = div_rsp.busy;
  assign stat.res_pending = (state_r == S_OUT);
  assign out_tvalid       = out_valid_r;
  assign out_tdata        = out_data_r;

endmodule

FILE: rtl/polynomial_string_hash_top.sv
// Top level of the polynomial string hash: configuration registers, the
// character queue and the accumulator. Depends on phs_pkg, phs_fifo, phs_acc.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Word contents
//  ---------+-----------+------------------------------------------------
//  in_      | slave     | tdata[7:0] char_code (signed), tlast last_char
//  out_     | master    | tdata[63:0] hash_value
//  cfg_     | APB slave | 0x0 base, 0x8 modulus (64-bit registers)
//
//  In the accumulator each character is first registered in S_IDLE as the
//  character product and the partial products of the next power, then added
//  in S_ADD. A last character with a non-zero modulus then waits in S_DIV for
//  the restoring remainder unit (64 steps, then the remainder is collected) and
//  moves to S_OUT to load the output register; with a zero modulus, straight there.
//  Reset is synchronous and active low; it restores base 31, modulus 1, an
//  empty sum and a power of one. A stalled output holds back the accumulator,
//  while the two-word queue keeps taking characters until it is full.

module polynomial_string_hash_top import phs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,    // [7:0] char_code
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [HASH_W-1:0] out_tdata,   // [63:0] hash_value
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [HASH_W-1:0] cfg_pwdata,
  output logic [HASH_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [HASH_W-1:0] base_r;
  logic [HASH_W-1:0] modulus_r;
  logic              cfg_wr;
  logic              reg_sel;
  phs_item_t         in_item;
  phs_item_t         q_item;
  logic              q_valid;
  logic              q_pop;
  phs_stat_t         back_stat;

  // The register is picked by address bit 3 alone; the low bits are not
  // decoded, so every write lands in one of the two registers.
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= BASE_RESET;
      modulus_r <= MOD_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_BASE:    base_r    <= cfg_pwdata;
        REG_MODULUS: modulus_r <= cfg_pwdata;
        default:     base_r    <= base_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BASE:    cfg_prdata = base_r;
      REG_MODULUS: cfg_prdata = modulus_r;
      default:     cfg_prdata = '0;
    endcase
  end

  assign in_item.char_code = in_tdata;
  assign in_item.last_char = in_tlast;

  phs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid),
    .push_item  (in_item),
    .can_push   (in_tready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  phs_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .base       (base_r),
    .modulus    (modulus_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .stat       (back_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The accumulator takes no character while a reduction runs or a result
  // waits, and never takes two characters in consecutive cycles.
`include "polynomial_string_hash_top_assert.svh"

  `PHS_ASSERT_NOW(a_no_pop_div, back_stat.div_busy, !q_pop, "character taken during reduction")
  `PHS_ASSERT_NOW(a_no_pop_res, back_stat.res_pending, !q_pop, "character taken with result held")
  `PHS_ASSERT_NEXT(a_pop_gap, q_pop, !q_pop, "characters taken back to back")

endmodule

FILE: test/tb.sv
// Self-checking testbench for the polynomial string hash block.
// Depends on phs_pkg and polynomial_string_hash_top; a scoreboard class predicts each hash.
`timescale 1ns / 1ps

// Tracks the configuration, the partial sum and the running power of the base,
// and holds the hashes that the block still owes.
class hash_scoreboard;
  logic [phs_pkg::HASH_W-1:0] base_reg;
  logic [phs_pkg::HASH_W-1:0] modulus_reg;
  logic [phs_pkg::HASH_W-1:0] partial_sum;
  logic [phs_pkg::HASH_W-1:0] base_power;
  logic [phs_pkg::HASH_W-1:0] owed_hashes[$];
  int                         string_count;
  int                         mismatches;

  function new();
    base_reg     = phs_pkg::BASE_RESET;
    modulus_reg  = phs_pkg::MOD_RESET;
    partial_sum  = '0;
    base_power   = 64'd1;
    string_count = 0;
    mismatches   = 0;
  endfunction

  function void set_reg(logic reg_sel, logic [phs_pkg::HASH_W-1:0] value);
    if (reg_sel == phs_pkg::REG_BASE) begin
      base_reg = value;
    end else begin
      modulus_reg = value;
    end
  endfunction

  function int outstanding();
    return owed_hashes.size();
  endfunction

  // Called for every character word that the block accepts.
  function void note_char(logic [phs_pkg::CHAR_W-1:0] code, logic last);
    logic [phs_pkg::HASH_W-1:0] widened;
    widened = {{(phs_pkg::HASH_W - phs_pkg::CHAR_W){code[phs_pkg::CHAR_W-1]}}, code};
    // Both the product and the sum wrap at 64 bits.
    partial_sum = partial_sum + widened * base_power;
    base_power  = base_power * base_reg;
    if (last) begin
      // A zero modulus leaves the wrapped sum unreduced.
      owed_hashes.push_back((modulus_reg != '0) ? partial_sum % modulus_reg : partial_sum);
      partial_sum = '0;
      base_power  = 64'd1;
    end
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  task check_hash(logic [phs_pkg::HASH_W-1:0] got);
    logic [phs_pkg::HASH_W-1:0] want;
    if (owed_hashes.size() == 0) begin
      report_mismatch($sformatf("hash %h arrived with none outstanding", got));
    end else begin
      want = owed_hashes.pop_front();
      if (got !== want) begin
        report_mismatch($sformatf("string %0d: hash_value %h, expected %h",
                                  string_count, got, want));
      end
      string_count++;
    end
  endtask
endclass

module tb;
  import phs_pkg::*;

  // This pause covers a final modulo and the queue.
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [HASH_W-1:0] ALL_ONES = {HASH_W{1'b1}};
  localparam logic [HASH_W-1:0] TOP_BIT  = {1'b1, {(HASH_W-1){1'b0}}};

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [CHAR_W-1:0] in_tdata;    // [7:0] char_code
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [HASH_W-1:0] out_tdata;   // [63:0] hash_value
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [HASH_W-1:0] cfg_pwdata;
  logic [HASH_W-1:0] cfg_prdata;
  logic              cfg_pready;

  hash_scoreboard sb;

  int cycles;
  int chars_accepted;
  int burst_left;
  bit tx_steady;
  int rx_left;
  int rx_mode;
  int rx_tick;

  polynomial_string_hash_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a run that stops making progress fails here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side. Each hash word is checked at the edge that accepts it, and the
  // ready line follows a pattern of its own: always ready, coin-flip ready, or
  // ready for one cycle in ten, each for a random stretch of cycles.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_hash(out_tdata);
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= (rx_tick % 10 == 0);
    endcase
  end

  // Sends one character word. The sender works in bursts; between bursts it
  // may drop valid for a random gap, unless the current phase runs without gaps.
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = tx_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_char(code, last);
    chars_accepted++;
  endtask

  task automatic send_chars(input logic [CHAR_W-1:0] chars[$], input logic ends_string);
    foreach (chars[i]) begin
      send_char(chars[i], ends_string && (i == chars.size() - 1));
    end
  endtask

  // Random string; mostly short, now and then long enough to wrap the power
  // of the base many times over.
  task automatic send_random_string();
    int len;
    int pick;
    pick = $urandom_range(0, 9);
    len = (pick == 0) ? 1 : (pick < 8) ? $urandom_range(2, 12) : $urandom_range(13, 48);
    for (int i = 0; i < len; i++) begin
      send_char(CHAR_W'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Lets the block drain: every owed hash must have come out, then the block
  // gets time to finish any characters that produce no word.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup cycle, access cycle, then an idle cycle.
  task automatic write_reg(input logic reg_sel, input logic [HASH_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({reg_sel, 3'b000});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(reg_sel, value);
    @(posedge clk);
  endtask

  initial begin
    logic [CHAR_W-1:0] chars[$];
    logic [HASH_W-1:0] base_val;
    logic [HASH_W-1:0] mod_val;
    int                phase;
    int                phase_end;
    int                rand_stop;

    sb          = new();
    cycles      = 0;
    burst_left  = 0;
    tx_steady   = 1'b0;
    rx_left     = 0;
    rx_tick     = 0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: base 31 and modulus 1, so every hash reduces to zero.
    chars = '{8'h41, 8'h42};
    send_chars(chars, 1'b1);
    settle();

    // Modulus zero hands back the raw wrapped sum; the extreme characters
    // check the sign extension, and a one-character string is the char itself.
    write_reg(REG_MODULUS, '0);
    chars = '{8'h80};
    send_chars(chars, 1'b1);
    chars = '{8'h7f};
    send_chars(chars, 1'b1);
    chars = '{8'hff, 8'h00, 8'h01};
    send_chars(chars, 1'b1);
    settle();

    // Largest base and modulus.
    write_reg(REG_BASE, ALL_ONES);
    write_reg(REG_MODULUS, ALL_ONES);
    chars = '{8'h80, 8'h7f, 8'h80};
    send_chars(chars, 1'b1);
    settle();

    // A zero base leaves only the first character in the sum.
    write_reg(REG_BASE, '0);
    write_reg(REG_MODULUS, 64'd1000003);
    chars = '{8'h61, 8'h62, 8'h63};
    send_chars(chars, 1'b1);
    settle();

    // Registers rewritten part-way through a string: the new base applies from
    // the next power update, the new modulus at the closing character.
    write_reg(REG_BASE, 64'd31);
    write_reg(REG_MODULUS, '0);
    chars = '{8'h61, 8'h62};
    send_chars(chars, 1'b0);
    settle();
    write_reg(REG_BASE, 64'd37);
    write_reg(REG_MODULUS, 64'd997);
    chars = '{8'h63, 8'h64};
    send_chars(chars, 1'b1);
    settle();

    write_reg(REG_BASE, TOP_BIT);
    write_reg(REG_MODULUS, TOP_BIT);
    chars = '{8'h55, 8'haa, 8'h01, 8'hfe};
    send_chars(chars, 1'b1);

    // Random phases of whole strings, each under fresh settings. The first
    // two phases pin the extremes; later ones draw from edge and random values.
    rand_stop = chars_accepted + RANDOM_ITEMS;
    phase = 0;
    while (chars_accepted < rand_stop) begin
      settle();
      case (phase)
        0: begin
          base_val = ALL_ONES;
          mod_val  = ALL_ONES;
        end
        1: begin
          base_val = '0;
          mod_val  = '0;
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       base_val = '0;
            1:       base_val = 64'd1;
            2:       base_val = ALL_ONES;
            3:       base_val = TOP_BIT;
            4:       base_val = HASH_W'($urandom_range(2, 1000));
            default: base_val = {$urandom, $urandom};
          endcase
          case ($urandom_range(0, 5))
            0:       mod_val = '0;
            1:       mod_val = 64'd1;
            2:       mod_val = ALL_ONES;
            3:       mod_val = TOP_BIT;
            4:       mod_val = HASH_W'($urandom_range(2, 1000));
            default: mod_val = {$urandom, $urandom};
          endcase
        end
      endcase
      write_reg(REG_BASE, base_val);
      write_reg(REG_MODULUS, mod_val);
      tx_steady = ($urandom_range(0, 3) == 0);
      phase_end = chars_accepted + $urandom_range(100, 200);
      while (chars_accepted < phase_end) begin
        send_random_string();
      end
      phase++;
    end

    settle();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: polynomial_string_hash_top.f
+incdir+rtl
rtl/phs_pkg.sv
rtl/phs_fifo.sv
rtl/phs_div.sv
rtl/phs_acc.sv
rtl/polynomial_string_hash_top.sv
test/tb.sv
